// ----- rtl/tmf_pkg.sv -----
package tmf_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int CLASS_COUNT = 8;

    localparam int DIM_W = 9;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int CLS_W = 3;
    localparam int WIN_N = 9;
    localparam int CNT_W = $clog2(WIN_N + 1);

    typedef logic [CLS_W-1:0] class_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [DIM_W-1:0] dim_t;

    typedef enum logic
    {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        class_t upper;
        class_t lower;
    } line_pair_t;

    typedef struct packed
    {
        logic                  valid;
        logic                  last;
        class_t [WIN_N-1:0]    cls;
        logic   [WIN_N-1:0]    mask;
        class_t                best;
        count_t                best_cnt;
    } cell_data_t;

endpackage

// ----- rtl/tile_mode_filter_3x3.sv -----
// 3x3 mode filter over a raster stream of tile classes. Takes one tile per clock, sustained;
// s_tready drops only while a second finished result is parked in the output skid register.
// The result for raster index k leaves after input item k+width+1 has been taken. It passes
// the line buffer read, the window column shift, each of the 8 class cells and then the
// output register. The two previous rows sit in one line buffer RAM (one read and one
// write per item, with a bypass for back-to-back use of the same column); the line buffer
// is not cleared. After width*height tiles send width+1 padding transfers to flush the last
// cells; the last cell of the grid carries m_tlast and the next transfer starts a new pass.
// Any configuration write restarts the frame position.
module tile_mode_filter_3x3
    import tmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [2:0] tile
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] filtered_tile
    output logic       m_tlast,   // last_cell
    input  logic       cfg_we,
    input  reg_index_t cfg_index,
    input  dim_t       cfg_wdata
);

    typedef struct packed
    {
        logic has;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } item_info_t;

    typedef struct packed
    {
        class_t top;
        class_t mid;
        class_t bot;
    } column_t;

    dim_t       gw_reg;
    dim_t       gh_reg;
    col_t       col_reg;
    col_t       col_next;
    row_t       row_reg;
    row_t       row_next;

    dim_t       w_eff;
    dim_t       h_eff;
    col_t       wm1;
    row_t       hm1;
    col_t       ax;
    row_t       ay;
    class_t     tile_in;
    class_t     t_cur;
    col_t       cx;
    row_t       cy;
    item_info_t cur;
    logic       accept;
    logic       adv;

    logic       a_valid_reg;
    class_t     a_t_reg;
    col_t       a_ax_reg;
    item_info_t a_info_reg;

    line_pair_t mem_rdata;
    line_pair_t rd_eff;
    line_pair_t wr_data;
    logic       fwd_reg;
    line_pair_t fwd_data_reg;

    logic       b_valid_reg;
    item_info_t b_info_reg;
    column_t    win_reg [3];

    cell_data_t chain [CLASS_COUNT+1];
    logic [2:0] row_ok;
    logic [2:0] col_ok;

    logic       m_tvalid_reg;
    class_t     out_tile_reg;
    logic       out_last_reg;
    logic       skid_valid_reg;
    class_t     skid_tile_reg;
    logic       skid_last_reg;

    // ---------------- frame position and current item ----------------
    assign adv    = !skid_valid_reg;
    assign accept = s_tvalid && adv;

    always_comb
    begin
        if (gw_reg == '0)
        begin
            w_eff = dim_t'(1);
        end
        else if (gw_reg > dim_t'(MAX_WIDTH))
        begin
            w_eff = dim_t'(MAX_WIDTH);
        end
        else
        begin
            w_eff = gw_reg;
        end
        if (gh_reg == '0)
        begin
            h_eff = dim_t'(1);
        end
        else if (gh_reg > dim_t'(MAX_HEIGHT))
        begin
            h_eff = dim_t'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = gh_reg;
        end
        wm1 = col_t'(w_eff - dim_t'(1));
        hm1 = row_t'(h_eff - dim_t'(1));

        ax = (dim_t'(col_reg) >= w_eff) ? '0 : col_reg;
        ay = row_reg;

        tile_in = s_tdata[CLS_W-1:0];
        if (32'(tile_in) >= CLASS_COUNT)
        begin
            t_cur = class_t'(CLASS_COUNT - 1);
        end
        else
        begin
            t_cur = tile_in;
        end
        if (ay >= row_t'(h_eff))
        begin
            t_cur = '0;
        end

        if (ax != '0)
        begin
            cx      = ax - col_t'(1);
            cy      = ay - row_t'(1);
            cur.has = (ay != '0);
        end
        else
        begin
            cx      = wm1;
            cy      = ay - row_t'(2);
            cur.has = (ay >= row_t'(2));
        end
        cur.has      = cur.has && (cy < row_t'(h_eff));
        cur.last     = (cx == wm1) && (cy == hm1);
        cur.top_ok   = (cy != '0);
        cur.bot_ok   = (cy < hm1);
        cur.left_ok  = (cx != '0);
        cur.right_ok = (cx != wm1);

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (cur.has && cur.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (ax == wm1)
            begin
                col_next = '0;
                row_next = ay + row_t'(1);
            end
            else
            begin
                col_next = ax + col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= dim_t'(256);
            gh_reg  <= dim_t'(256);
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:  gw_reg <= cfg_wdata;
                    REG_GRID_HEIGHT: gh_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line buffer stage ----------------
    assign rd_eff  = fwd_reg ? fwd_data_reg : mem_rdata;
    assign wr_data = '{upper: rd_eff.lower, lower: a_t_reg};

    tmf_line_buf u_line_buf
    (
        .clk   (clk),
        .we    (adv && a_valid_reg),
        .waddr (a_ax_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (ax),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (accept)
            begin
                // the stage A write lands on this same edge
                fwd_reg <= a_valid_reg && (a_ax_reg == ax);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_t_reg      <= t_cur;
            a_ax_reg     <= ax;
            a_info_reg   <= cur;
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------- window columns ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_info_reg  <= '0;
            for (int c = 0; c < 3; c++)
            begin
                win_reg[c] <= '0;
            end
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg && a_info_reg.has;
            b_info_reg  <= a_info_reg;
            if (a_valid_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= '{top: rd_eff.upper, mid: rd_eff.lower, bot: a_t_reg};
            end
        end
    end

    assign row_ok = {b_info_reg.bot_ok, 1'b1, b_info_reg.top_ok};
    assign col_ok = {b_info_reg.right_ok, 1'b1, b_info_reg.left_ok};

    always_comb
    begin
        chain[0].valid = b_valid_reg;
        chain[0].last  = b_info_reg.last;
        for (int c = 0; c < 3; c++)
        begin
            chain[0].cls[c]     = win_reg[c].top;
            chain[0].cls[3 + c] = win_reg[c].mid;
            chain[0].cls[6 + c] = win_reg[c].bot;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                chain[0].mask[r*3 + c] = row_ok[r] & col_ok[c];
            end
        end
        chain[0].best     = chain[0].cls[4];
        chain[0].best_cnt = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            chain[0].best_cnt = chain[0].best_cnt
                + count_t'(chain[0].mask[i] && (chain[0].cls[i] == chain[0].cls[4]));
        end
    end

    // ---------------- class cells ----------------
    for (genvar i = 0; i < CLASS_COUNT; i++)
    begin : g_cell
        tmf_class_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .cls   (class_t'(i)),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (chain[CLASS_COUNT].valid)
        begin
            if (!m_tvalid_reg || m_tready)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_tile_reg <= skid_tile_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (chain[CLASS_COUNT].valid)
        begin
            if (!m_tvalid_reg || m_tready)
            begin
                out_tile_reg <= chain[CLASS_COUNT].best;
                out_last_reg <= chain[CLASS_COUNT].last;
            end
            else
            begin
                skid_tile_reg <= chain[CLASS_COUNT].best;
                skid_last_reg <= chain[CLASS_COUNT].last;
            end
        end
    end

    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - CLS_W){1'b0}}, out_tile_reg};
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid holds a result while the output register is empty");

    a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, row_reg} <= ({1'b0, row_t'(h_eff)} + (ROW_W+1)'(1))))
        else $error("row position ran past the flush rows");

    a_frame_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cur.has && cur.last) |=> (col_reg == '0 && row_reg == '0))
        else $error("frame position not restarted after last cell");

endmodule

// ----- rtl/tmf_line_buf.sv -----
module tmf_line_buf
    import tmf_pkg::*;
(
    input  logic       clk,
    input  logic       we,
    input  col_t       waddr,
    input  line_pair_t wdata,
    input  logic       re,
    input  col_t       raddr,
    output line_pair_t rdata
);

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tmf_class_cell.sv -----
module tmf_class_cell
    import tmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  class_t     cls,
    input  cell_data_t din,
    output cell_data_t dout
);

    cell_data_t dout_reg;
    cell_data_t dout_next;
    count_t     cnt;

    // count this cell's class in the window, take over on a strictly greater count
    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            cnt = cnt + count_t'(din.mask[i] && (din.cls[i] == cls));
        end
        dout_next = din;
        if (cnt > din.best_cnt)
        begin
            dout_next.best     = cls;
            dout_next.best_cnt = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- dv/tile_mode_filter_3x3_test.sv -----
`timescale 1ns / 1ps

module tile_mode_filter_3x3_test;
    import tmf_pkg::*;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int MAX_REPORTS   = 100;

    typedef enum logic
    {
        ROW_TILE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t  kind;
        reg_index_t sel;
        dim_t       value;
        logic       typed;
        logic       has;
        class_t     mode;
        logic       last;
    } plan_row_t;

    typedef struct packed
    {
        class_t tile;
        logic   last;
    } cell_mode_t;

    localparam int DIRECTED_ROWS = 29;

    // typed rows: early items after reset, and a single-cell grid
    localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd3,   1'b1, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd6,   1'b1, 1'b0, 3'd0, 1'b0},
        '{ROW_WRITE, REG_GRID_WIDTH,  9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_WRITE, REG_GRID_HEIGHT, 9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd5,   1'b1, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b1, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b1, 1'b1, 3'd5, 1'b1},
        '{ROW_WRITE, REG_GRID_WIDTH,  9'd3,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_WRITE, REG_GRID_HEIGHT, 9'd3,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd4,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd7,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd0,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_WRITE, REG_GRID_WIDTH,  9'd2,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_WRITE, REG_GRID_HEIGHT, 9'd511, 1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd1,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd2,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd6,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd3,   1'b0, 1'b0, 3'd0, 1'b0},
        '{ROW_TILE,  REG_GRID_WIDTH,  9'd4,   1'b0, 1'b0, 3'd0, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [2:0] tile
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [2:0] filtered_tile
    logic       m_tlast;   // last_cell
    logic       cfg_we;
    reg_index_t cfg_index;
    dim_t       cfg_wdata;

    // predicted block state
    dim_t             width_reg  = 9'd256;
    dim_t             height_reg = 9'd256;
    bit [CLS_W-1:0]   older_row [MAX_WIDTH];
    bit [CLS_W-1:0]   newer_row [MAX_WIDTH];
    bit [CLS_W-1:0]   win [WIN_N];
    int               next_col;
    int               next_row;

    cell_mode_t expected_modes [$];
    int         mismatches;
    int         cycle_count;
    bit         tx_burst;
    bit         rx_burst;

    tile_mode_filter_3x3 uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int dim_in_use(input dim_t v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // slide the window by one item and work out the mode of the cell that completes now
    task automatic next_mode(input class_t tile, output bit produced, output cell_mode_t res);
        int w;
        int h;
        int ax;
        int ay;
        int cx;
        int cy;
        int tally [CLASS_COUNT];
        class_t t;
        class_t best;
        w  = dim_in_use(width_reg, MAX_WIDTH);
        h  = dim_in_use(height_reg, MAX_HEIGHT);
        ax = (next_col >= w) ? 0 : next_col;
        ay = next_row;
        t  = (ay >= h) ? class_t'(0) : tile;
        for (int r = 0; r < 3; r++)
        begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = older_row[ax];
        win[5] = newer_row[ax];
        win[8] = t;
        older_row[ax] = newer_row[ax];
        newer_row[ax] = t;
        if (ax >= 1)
        begin
            cx = ax - 1;
            cy = ay - 1;
            produced = (ay >= 1);
        end
        else
        begin
            cx = w - 1;
            cy = ay - 2;
            produced = (ay >= 2);
        end
        if (produced && cy >= h)
            produced = 1'b0;
        if (ax + 1 >= w)
        begin
            next_col = 0;
            next_row = ay + 1;
        end
        else
        begin
            next_col = ax + 1;
            next_row = ay;
        end
        res = '0;
        if (produced)
        begin
            foreach (tally[i])
                tally[i] = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (!(r == 0 && cy < 1) && !(r == 2 && cy + 1 >= h) &&
                        !(c == 0 && cx < 1) && !(c == 2 && cx + 1 >= w))
                        tally[win[r*3+c]]++;
            best = win[4];
            for (int k = 0; k < CLASS_COUNT; k++)
                if (tally[k] > tally[best])
                    best = class_t'(k);
            res.tile = best;
            res.last = (cx == w - 1 && cy == h - 1);
            if (res.last)
            begin
                next_col = 0;
                next_row = 0;
            end
        end
    endtask

    task automatic send_tile(input class_t tile, input bit typed, input bit typed_has,
                             input cell_mode_t typed_mode);
        int gap;
        bit produced;
        cell_mode_t res;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, tile};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        next_mode(tile, produced, res);
        if (typed)
        begin
            produced = typed_has;
            res      = typed_mode;
        end
        if (produced)
            expected_modes.push_back(res);
    endtask

    // only while idle: all results in, then the pipeline tail
    task automatic write_register(input reg_index_t sel, input dim_t value);
        s_tvalid <= 1'b0;
        while (expected_modes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_GRID_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        next_col = 0;
        next_row = 0;
    endtask

    always @(posedge clk)
    begin : watch_results
        cell_mode_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_modes.size() == 0)
                report_mismatch($sformatf("unexpected result, filtered_tile %0d",
                                          m_tdata[2:0]));
            else
            begin
                want = expected_modes.pop_front();
                if (m_tdata[2:0] !== want.tile)
                    report_mismatch($sformatf("filtered_tile %0d, expected %0d",
                                              m_tdata[2:0], want.tile));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_cell %0b, expected %0b",
                                              m_tlast, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tile_mode_filter_3x3_test failed");
            $finish;
        end
    end

    initial
    begin : receiver
        int stall;
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin : stimulus
        plan_row_t  row;
        int         frame;
        int         small_items;
        int         cols;
        int         rows;
        int         tiles;
        int         pads;
        int         shape;
        bit         special;
        bit         must_write;
        bit         uniform;
        dim_t       w_raw;
        dim_t       h_raw;
        class_t     palette [3];
        class_t     t;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_GRID_WIDTH;
        cfg_wdata   <= '0;
        next_col    = 0;
        next_row    = 0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE)
                write_register(row.sel, row.value);
            else
                send_tile(row.value[2:0], row.typed, row.has, '{tile: row.mode, last: row.last});
        end

        frame       = 0;
        small_items = 0;
        must_write  = 1'b1;
        w_raw       = 9'd2;
        h_raw       = 9'd511;
        while (small_items < RANDOM_ITEMS)
        begin
            special = (frame == 2 || frame == 5);
            if (special || must_write || $urandom_range(0, 3) != 0)
            begin
                if (frame == 2)
                begin
                    w_raw = 9'd511;
                    h_raw = 9'd1;
                end
                else if (frame == 5)
                begin
                    w_raw = 9'd1;
                    h_raw = 9'd256;
                end
                else
                begin
                    w_raw = dim_t'($urandom_range(0, 9));
                    h_raw = dim_t'($urandom_range(0, 9));
                end
                write_register(REG_GRID_WIDTH, w_raw);
                write_register(REG_GRID_HEIGHT, h_raw);
            end
            cols  = dim_in_use(w_raw, MAX_WIDTH);
            rows  = dim_in_use(h_raw, MAX_HEIGHT);
            tiles = cols * rows;
            pads  = cols + 1;
            shape = special ? 9 : $urandom_range(0, 9);
            must_write = special;
            if (shape == 0)
            begin
                // aborted pass, restarted by the next write
                tiles      = $urandom_range(1, tiles);
                pads       = 0;
                must_write = 1'b1;
            end
            else if (shape == 1)
            begin
                pads       = $urandom_range(0, cols + 3);
                must_write = 1'b1;
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            uniform  = ($urandom_range(0, 3) == 0);
            foreach (palette[k])
                palette[k] = class_t'($urandom_range(0, 7));
            for (int i = 0; i < tiles; i++)
            begin
                if (uniform || $urandom_range(0, 4) == 0)
                    t = class_t'($urandom_range(0, 7));
                else
                    t = palette[$urandom_range(0, 2)];
                send_tile(t, 1'b0, 1'b0, '0);
            end
            for (int i = 0; i < pads; i++)
                send_tile(class_t'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
            small_items += tiles + pads;
            frame++;
        end

        s_tvalid <= 1'b0;
        while (expected_modes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tile_mode_filter_3x3_test passed");
        else
            $display("tile_mode_filter_3x3_test failed");
        $finish;
    end

endmodule
